### rtl/core/prpg_pkg.sv
// Package for the pulse ramp profile generator: sequencer states, phase codes,
// register indexes and fixed arithmetic constants.
// No dependencies.
package prpg_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_SCALE,
        ST_SAT,
        ST_OUT
    } state_t;

    // ramp_phase codes
    localparam logic [1:0] PHASE_DECEL  = 2'd0;
    localparam logic [1:0] PHASE_ACCEL  = 2'd1;
    localparam logic [1:0] PHASE_CRUISE = 2'd2;
    localparam logic [1:0] PHASE_HOLD   = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 24;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_MODE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_MS      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_FREQ   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_RATE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_FREQ  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_PULSES = 3'd5;

    // divider geometry: dividend fits 30 bits, divisor clamped to 31 bits
    localparam int unsigned DVD_BITS   = 30;
    localparam int unsigned DIVR_BITS  = 31;
    localparam int unsigned LIMIT_BITS = 20;
    localparam int unsigned START_BITS = 33;
    localparam int unsigned CNT5_BITS  = 5;

    localparam logic [DVD_BITS-1:0]   DIVIDEND_PERIOD = 30'd1_000_000_000;
    localparam logic [DVD_BITS-1:0]   DIVIDEND_CRUISE = 30'd100_000_000;
    localparam logic [15:0]           SCALE_K         = 16'd10000;
    localparam logic [START_BITS-1:0] START_K_SCALED  = 33'd100000;
    localparam logic [START_BITS-1:0] START_K_PLAIN   = 33'd10;
    localparam logic [LIMIT_BITS-1:0] RAMP_TICKS_K    = 20'd10;

endpackage

### rtl/core/pulse_ramp_profile_generator_top.sv
// Pulse ramp profile generator: trapezoidal ramp sequencer with one shared
// multiplier and a radix-2 restoring divider. Depends on prpg_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, pulses_remaining) carries one timer
//   tick per transaction. Output channel (out_valid/out_ready) returns one
//   transaction per tick: period_word, write_valid, divide_fault, ramp_phase.
//   Config port (cfg_we, cfg_index, cfg_data) writes one register per cycle;
//   write only while the block is idle.
//   Processing: accelerating/decelerating ticks pass through multiply, sum,
//   the divider loop, scale and, for the scaled period, saturate; cruise
//   start goes through the divider loop and scale; holding ticks and a zero
//   cruise target go straight to output, a zero period divisor after sum.
//   The 30-step divider loop dominates; one tick is in flight at a time, and
//   after the output handshake the block returns to idle before the next tick.
//   in_ready is high only in idle; the result is held in output registers
//   while out_ready is low, and the next tick is taken after it leaves.
//   Reset (rst_n low, async) restores register defaults and clears the ramp
//   counters; no clearing pass is needed.
module pulse_ramp_profile_generator_top #(
    parameter int unsigned COUNT_BITS = 24,
    parameter int unsigned STEP_BITS  = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [prpg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [prpg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [23:0]                          pulses_remaining,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [31:0]                          period_word,
    output logic                                 write_valid,
    output logic                                 divide_fault,
    output logic [1:0]                           ramp_phase
);
    import prpg_pkg::*;

    localparam int unsigned MAW  = (STEP_BITS > DVD_BITS) ? STEP_BITS : DVD_BITS;
    localparam int unsigned MW   = MAW + 16;
    localparam int unsigned SW   = MW + 1;
    localparam int unsigned CW   = (STEP_BITS > LIMIT_BITS) ? STEP_BITS : LIMIT_BITS;
    localparam int unsigned CNTW = (COUNT_BITS > 24) ? COUNT_BITS : 24;

    state_t state_reg, state_next;

    logic                    period_mode_reg;
    logic [15:0]             ramp_ms_reg;
    logic [15:0]             start_freq_reg;
    logic [15:0]             ramp_rate_reg;
    logic [23:0]             target_freq_reg;
    logic [23:0]             total_pulses_reg;

    logic [STEP_BITS-1:0]    ramp_step_reg, ramp_step_next;
    logic [STEP_BITS-1:0]    decel_step_reg, decel_step_next;
    logic [COUNT_BITS-1:0]   accel_cnt_reg, accel_cnt_next;

    logic [STEP_BITS-1:0]    step_op_reg, step_op_next;
    logic [MW-1:0]           prod_reg, prod_next;
    logic [DIVR_BITS-1:0]    divisor_reg, divisor_next;
    logic [DVD_BITS-1:0]     dvd_reg, dvd_next;
    logic [DIVR_BITS-1:0]    rem_reg, rem_next;
    logic [CNT5_BITS-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [31:0]             word_reg, word_next;
    logic                    fault_reg, fault_next;
    logic                    valid_reg, valid_next;
    logic [1:0]              phase_reg, phase_next;

    // tick classification
    logic [LIMIT_BITS-1:0]   limit;
    logic                    is_decel, ramp_lt, ramp_eq;
    logic [STEP_BITS-1:0]    ramp_inc, decel_dec;
    logic [CNTW-1:0]         cnt_diff;

    // shared multiplier
    logic [MAW-1:0]          mul_a;
    logic [15:0]             mul_b;
    logic [MW-1:0]           mul_p;

    // divisor formation and divider step
    logic [START_BITS-1:0]   start_term;
    logic [SW-1:0]           div_sum;
    logic [DIVR_BITS:0]      trial, trial_sub;
    logic                    trial_ge;
    logic                    div_last;

    assign limit     = ramp_ms_reg * RAMP_TICKS_K;
    assign is_decel  = CNTW'(pulses_remaining) < CNTW'(accel_cnt_reg);
    assign ramp_lt   = CW'(ramp_step_reg) < CW'(limit);
    assign ramp_eq   = CW'(ramp_step_reg) == CW'(limit);
    assign ramp_inc  = ramp_step_reg + STEP_BITS'(1);
    assign decel_dec = (decel_step_reg != '0) ? decel_step_reg - STEP_BITS'(1) : decel_step_reg;
    assign cnt_diff  = CNTW'(total_pulses_reg) - CNTW'(pulses_remaining);

    assign mul_a = (state_reg == ST_MUL) ? MAW'(step_op_reg) : MAW'(dvd_reg);
    assign mul_b = (state_reg == ST_MUL) ? ramp_rate_reg : SCALE_K;
    assign mul_p = MW'(mul_a) * MW'(mul_b);

    assign start_term = period_mode_reg ? START_BITS'(start_freq_reg) * START_K_SCALED
                                        : START_BITS'(start_freq_reg) * START_K_PLAIN;
    assign div_sum    = SW'(prod_reg) + SW'(start_term);

    assign trial     = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign trial_ge  = trial >= {1'b0, divisor_reg};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign div_last  = bit_cnt_reg == CNT5_BITS'(DVD_BITS - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_decel || ramp_lt)
                        state_next = ST_MUL;
                    else if (ramp_eq && (target_freq_reg != '0))
                        state_next = ST_DIV;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = (div_sum == '0) ? ST_OUT : ST_DIV;
            ST_DIV:   state_next = div_last ? ST_SCALE : ST_DIV;
            ST_SCALE:
            begin
                if (period_mode_reg && (phase_reg != PHASE_CRUISE))
                    state_next = ST_SAT;
                else
                    state_next = ST_OUT;
            end
            ST_SAT:   state_next = ST_OUT;
            ST_OUT:   state_next = out_ready ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_OUT:  out_valid = 1'b1;
            default:
            begin
                in_ready  = 1'b0;
                out_valid = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        ramp_step_next  = ramp_step_reg;
        decel_step_next = decel_step_reg;
        accel_cnt_next  = accel_cnt_reg;
        step_op_next    = step_op_reg;
        prod_next       = prod_reg;
        divisor_next    = divisor_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        bit_cnt_next    = bit_cnt_reg;
        word_next       = word_reg;
        fault_next      = fault_reg;
        valid_next      = valid_reg;
        phase_next      = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    word_next  = '0;
                    fault_next = 1'b0;
                    valid_next = 1'b1;
                    if (is_decel)
                    begin
                        decel_step_next = decel_dec;
                        step_op_next    = decel_dec;
                        phase_next      = PHASE_DECEL;
                    end
                    else if (ramp_lt)
                    begin
                        ramp_step_next  = ramp_inc;
                        decel_step_next = ramp_inc;
                        accel_cnt_next  = cnt_diff[COUNT_BITS-1:0];
                        step_op_next    = ramp_inc;
                        phase_next      = PHASE_ACCEL;
                    end
                    else if (ramp_eq)
                    begin
                        ramp_step_next = ramp_inc;
                        accel_cnt_next = cnt_diff[COUNT_BITS-1:0];
                        phase_next     = PHASE_CRUISE;
                        divisor_next   = DIVR_BITS'(target_freq_reg);
                        dvd_next       = DIVIDEND_CRUISE;
                        rem_next       = '0;
                        bit_cnt_next   = '0;
                        if (target_freq_reg == '0)
                        begin
                            word_next  = '1;
                            fault_next = 1'b1;
                        end
                    end
                    else
                    begin
                        valid_next = 1'b0;
                        phase_next = PHASE_HOLD;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = mul_p;
            end
            ST_SUM:
            begin
                dvd_next     = DIVIDEND_PERIOD;
                rem_next     = '0;
                bit_cnt_next = '0;
                // anything at or above 2^31 exceeds the dividend: quotient is zero
                divisor_next = (|div_sum[SW-1:DIVR_BITS]) ? '1 : div_sum[DIVR_BITS-1:0];
                if (div_sum == '0)
                begin
                    word_next  = '1;
                    fault_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                rem_next     = trial_ge ? trial_sub[DIVR_BITS-1:0] : trial[DIVR_BITS-1:0];
                dvd_next     = {dvd_reg[DVD_BITS-2:0], trial_ge};
                bit_cnt_next = bit_cnt_reg + CNT5_BITS'(1);
            end
            ST_SCALE:
            begin
                prod_next = mul_p;
                word_next = 32'(dvd_reg);
            end
            ST_SAT:
            begin
                word_next = (|prod_reg[MW-1:32]) ? '1 : prod_reg[31:0];
            end
            ST_OUT:
            begin
                word_next = word_reg;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            period_mode_reg  <= 1'b0;
            ramp_ms_reg      <= 16'd100;
            start_freq_reg   <= 16'd100;
            ramp_rate_reg    <= 16'd1;
            target_freq_reg  <= 24'd1000;
            total_pulses_reg <= '0;
            ramp_step_reg    <= '0;
            decel_step_reg   <= '0;
            accel_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ramp_step_reg  <= ramp_step_next;
            decel_step_reg <= decel_step_next;
            accel_cnt_reg  <= accel_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PERIOD_MODE:  period_mode_reg  <= cfg_data[0];
                    REG_RAMP_MS:      ramp_ms_reg      <= cfg_data[15:0];
                    REG_START_FREQ:   start_freq_reg   <= cfg_data[15:0];
                    REG_RAMP_RATE:    ramp_rate_reg    <= cfg_data[15:0];
                    REG_TARGET_FREQ:  target_freq_reg  <= cfg_data[23:0];
                    REG_TOTAL_PULSES: total_pulses_reg <= cfg_data[23:0];
                    default:          period_mode_reg  <= period_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_op_reg <= step_op_next;
        prod_reg    <= prod_next;
        divisor_reg <= divisor_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        word_reg    <= word_next;
        fault_reg   <= fault_next;
        valid_reg   <= valid_next;
        phase_reg   <= phase_next;
    end

    assign period_word  = word_reg;
    assign write_valid  = valid_reg;
    assign divide_fault = fault_reg;
    assign ramp_phase   = phase_reg;

endmodule
